// ===== rtl/core/motor_position_command_decoder_defines.svh =====
// assertion macros for the motor position command decoder
`ifndef MOTOR_POSITION_COMMAND_DECODER_DEFINES_SVH
`define MOTOR_POSITION_COMMAND_DECODER_DEFINES_SVH

// same-cycle implication, sampled on aclk, off during reset
`define MPCD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, off during reset
`define MPCD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/mpcd_pkg.sv =====
package mpcd_pkg;

    localparam int unsigned FRAME_LEN = 12;
    localparam int unsigned CMD_LEN   = 5;
    localparam int unsigned POS_W     = 20;
    localparam int unsigned SPU_W     = 9;
    localparam int unsigned DATA_W    = 32;
    localparam int unsigned IDX_W     = 4;

    localparam logic [IDX_W-1:0] IDX_FIRST      = '0;
    localparam logic [IDX_W-1:0] IDX_CMD_LAST   = IDX_W'(CMD_LEN);
    localparam logic [IDX_W-1:0] IDX_FRAME_LAST = IDX_W'(FRAME_LEN - 1);
    localparam logic [IDX_W-1:0] IDX_LIMIT      = IDX_W'(FRAME_LEN);

    localparam logic [7:0] CHAR_START = 8'h78;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [8*CMD_LEN-1:0] NAME_AUCAL = "aucal";
    localparam logic [8*CMD_LEN-1:0] NAME_GETPO = "getpo";
    localparam logic [8*CMD_LEN-1:0] NAME_GO_UP = "go_up";
    localparam logic [8*CMD_LEN-1:0] NAME_GO_DW = "go_dw";
    localparam logic [8*CMD_LEN-1:0] NAME_GO_TO = "go_to";

    localparam logic [POS_W-1:0] MIN_POSITION_RESET   = 20'd0;
    localparam logic [POS_W-1:0] MAX_POSITION_RESET   = 20'd999999;
    localparam logic [SPU_W-1:0] STEPS_PER_UNIT_RESET = 9'd1;

    typedef enum logic [2:0] {
        CMD_AUCAL   = 3'd0,
        CMD_GETPO   = 3'd1,
        CMD_GO_UP   = 3'd2,
        CMD_GO_DW   = 3'd3,
        CMD_GO_TO   = 3'd4,
        CMD_UNKNOWN = 3'd5
    } cmd_t;

    typedef enum logic [2:0] {
        KIND_MOVE     = 3'd0,
        KIND_HOME     = 3'd1,
        KIND_REPORT   = 3'd2,
        KIND_STOP_ERR = 3'd3,
        KIND_UNKNOWN  = 3'd4,
        KIND_FRAMING  = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        PH_LEAD = 2'd0,
        PH_NUM  = 2'd1,
        PH_DONE = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        CFG_MIN_POSITION   = 2'd0,
        CFG_MAX_POSITION   = 2'd1,
        CFG_STEPS_PER_UNIT = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic              start_ok;
        cmd_t              cmd;
        logic [DATA_W-1:0] value;
        logic              negative;
        logic              stop_fwd;
        logic              stop_rev;
    } frame_t;

    typedef struct packed {
        kind_t             kind;
        logic              direction;
        logic [DATA_W-1:0] distance;
        logic [DATA_W-1:0] position;
    } exec_t;

endpackage

// ===== rtl/core/motor_position_command_decoder.sv =====
// Serial command decoder for a stepper axis. Received bytes come in one per s_ beat; CR and LF
// are dropped and every twelve remaining bytes form a frame of 'x', a five-letter command and
// a six-character value read the way atol reads it. go_up, go_dw and go_to give a move with
// direction and step count (distance times steps_per_unit, modulo 2^32), aucal homes against
// the end stops sampled with the twelfth byte, getpo reports the tracked position, and bad
// frames or commands give an error result; a go_to to the current position gives no result.
// One byte is taken every cycle while m_ready holds; a result passes from its twelfth byte through
// the input, frame and command registers to the output register, which also registers the step
// multiply. Configuration writes are always ready and should be made while the block is idle.
module motor_position_command_decoder
    import mpcd_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [1:0]               cfg_index,
    input  logic [POS_W-1:0]         cfg_wdata,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [7:0]               s_rx_byte,
    input  logic                     s_end_stop_forward,
    input  logic                     s_end_stop_reverse,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [2:0]               m_result_kind,
    output logic                     m_direction,
    output logic [DATA_W-1:0]        m_step_count,
    output logic signed [DATA_W-1:0] m_position
);

    logic [POS_W-1:0] min_position_reg, min_position_next;
    logic [POS_W-1:0] max_position_reg, max_position_next;
    logic [SPU_W-1:0] steps_per_unit_reg, steps_per_unit_next;

    logic   frame_valid;
    frame_t frame;
    logic   frame_ready;
    logic   ex_valid;
    exec_t  ex;
    logic   ex_ready;

    assign cfg_ready = 1'b1;

    always_comb begin
        min_position_next   = min_position_reg;
        max_position_next   = max_position_reg;
        steps_per_unit_next = steps_per_unit_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_MIN_POSITION:   min_position_next   = cfg_wdata;
                CFG_MAX_POSITION:   max_position_next   = cfg_wdata;
                CFG_STEPS_PER_UNIT: steps_per_unit_next = cfg_wdata[SPU_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_position_reg   <= MIN_POSITION_RESET;
            max_position_reg   <= MAX_POSITION_RESET;
            steps_per_unit_reg <= STEPS_PER_UNIT_RESET;
        end else begin
            min_position_reg   <= min_position_next;
            max_position_reg   <= max_position_next;
            steps_per_unit_reg <= steps_per_unit_next;
        end
    end

    mpcd_parser u_parser (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_rx_byte          (s_rx_byte),
        .s_end_stop_forward (s_end_stop_forward),
        .s_end_stop_reverse (s_end_stop_reverse),
        .frame_valid        (frame_valid),
        .frame              (frame),
        .frame_ready        (frame_ready)
    );

    mpcd_exec u_exec (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .min_position (min_position_reg),
        .max_position (max_position_reg),
        .frame_valid  (frame_valid),
        .frame        (frame),
        .frame_ready  (frame_ready),
        .ex_valid     (ex_valid),
        .ex           (ex),
        .ex_ready     (ex_ready)
    );

    mpcd_output u_output (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .steps_per_unit (steps_per_unit_reg),
        .ex_valid       (ex_valid),
        .ex             (ex),
        .ex_ready       (ex_ready),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_kind  (m_result_kind),
        .m_direction    (m_direction),
        .m_step_count   (m_step_count),
        .m_position     (m_position)
    );

endmodule

// ===== rtl/core/mpcd_parser.sv =====
module mpcd_parser
    import mpcd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    input  logic       s_end_stop_forward,
    input  logic       s_end_stop_reverse,
    output logic       frame_valid,
    output frame_t     frame,
    input  logic       frame_ready
);

    logic              in_valid_reg, in_valid_next;
    logic [7:0]        in_byte_reg;
    logic              in_fwd_reg;
    logic              in_rev_reg;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              start_ok_reg, start_ok_next;
    logic [7:0]        cmd_reg [CMD_LEN];
    phase_t            phase_reg, phase_next;
    logic [DATA_W-1:0] acc_reg, acc_next;
    logic              neg_reg, neg_next;
    logic              frame_valid_reg, frame_valid_next;
    frame_t            frame_reg;
    frame_t            frame_next;

    logic              advance;
    logic              is_eol;
    logic              take_byte;
    logic              frame_end;
    logic [IDX_W-1:0]  idx;
    logic              is_digit;
    logic              is_blank;
    logic [DATA_W-1:0] acc_times10;
    logic [DATA_W-1:0] digit_value;
    phase_t            phase_p;
    logic [DATA_W-1:0] acc_p;
    logic              neg_p;
    logic [2:0]        cmd_sel;
    logic [8*CMD_LEN-1:0] cmd_word;
    cmd_t              cmd_code;

    assign advance   = in_valid_reg && (!frame_valid_reg || frame_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign is_eol    = (in_byte_reg == CHAR_LF) || (in_byte_reg == CHAR_CR);
    assign take_byte = advance && !is_eol;
    assign idx       = (idx_reg >= IDX_LIMIT) ? IDX_FIRST : idx_reg;
    assign frame_end = take_byte && (idx == IDX_FRAME_LAST);
    assign cmd_sel   = 3'(idx - 4'd1);

    assign is_digit    = (in_byte_reg >= CHAR_ZERO) && (in_byte_reg <= CHAR_NINE);
    assign is_blank    = (in_byte_reg == CHAR_SPACE) ||
                         ((in_byte_reg >= CHAR_TAB) && (in_byte_reg <= CHAR_CR));
    assign acc_times10 = {acc_reg[DATA_W-4:0], 3'b000} + {acc_reg[DATA_W-2:0], 1'b0};
    assign digit_value = {24'd0, in_byte_reg - CHAR_ZERO};

    // atol-style value scan, one character per beat
    always_comb begin
        phase_p = phase_reg;
        acc_p   = acc_reg;
        neg_p   = neg_reg;
        if (phase_reg == PH_LEAD && is_blank) begin
            phase_p = PH_LEAD;
        end else if (phase_reg == PH_LEAD &&
                     (in_byte_reg == CHAR_PLUS || in_byte_reg == CHAR_MINUS)) begin
            neg_p   = (in_byte_reg == CHAR_MINUS);
            phase_p = PH_NUM;
        end else if ((phase_reg == PH_LEAD || phase_reg == PH_NUM) && is_digit) begin
            acc_p   = acc_times10 + digit_value;
            phase_p = PH_NUM;
        end else begin
            phase_p = PH_DONE;
        end
    end

    assign cmd_word = {cmd_reg[0], cmd_reg[1], cmd_reg[2], cmd_reg[3], cmd_reg[4]};

    always_comb begin
        if (cmd_word == NAME_AUCAL) begin
            cmd_code = CMD_AUCAL;
        end else if (cmd_word == NAME_GETPO) begin
            cmd_code = CMD_GETPO;
        end else if (cmd_word == NAME_GO_UP) begin
            cmd_code = CMD_GO_UP;
        end else if (cmd_word == NAME_GO_DW) begin
            cmd_code = CMD_GO_DW;
        end else if (cmd_word == NAME_GO_TO) begin
            cmd_code = CMD_GO_TO;
        end else begin
            cmd_code = CMD_UNKNOWN;
        end
    end

    always_comb begin
        in_valid_next = s_ready ? s_valid : in_valid_reg;
        idx_next      = idx_reg;
        start_ok_next = start_ok_reg;
        phase_next    = phase_reg;
        acc_next      = acc_reg;
        neg_next      = neg_reg;
        if (take_byte) begin
            idx_next = frame_end ? IDX_FIRST : idx + 4'd1;
            if (idx == IDX_FIRST) begin
                start_ok_next = (in_byte_reg == CHAR_START);
                phase_next    = PH_LEAD;
                acc_next      = '0;
                neg_next      = 1'b0;
            end else if (idx > IDX_CMD_LAST) begin
                phase_next = phase_p;
                acc_next   = acc_p;
                neg_next   = neg_p;
            end
        end
        frame_valid_next = frame_end ? 1'b1 : (frame_ready ? 1'b0 : frame_valid_reg);

        frame_next.start_ok = start_ok_reg;
        frame_next.cmd      = cmd_code;
        frame_next.value    = acc_p;
        frame_next.negative = neg_p;
        frame_next.stop_fwd = in_fwd_reg;
        frame_next.stop_rev = in_rev_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            idx_reg         <= IDX_FIRST;
            start_ok_reg    <= 1'b0;
            phase_reg       <= PH_LEAD;
            acc_reg         <= '0;
            neg_reg         <= 1'b0;
            frame_valid_reg <= 1'b0;
        end else begin
            in_valid_reg    <= in_valid_next;
            idx_reg         <= idx_next;
            start_ok_reg    <= start_ok_next;
            phase_reg       <= phase_next;
            acc_reg         <= acc_next;
            neg_reg         <= neg_next;
            frame_valid_reg <= frame_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_rx_byte;
            in_fwd_reg  <= s_end_stop_forward;
            in_rev_reg  <= s_end_stop_reverse;
        end
        if (take_byte && idx != IDX_FIRST && idx <= IDX_CMD_LAST) begin
            cmd_reg[cmd_sel] <= in_byte_reg;
        end
        if (frame_end) begin
            frame_reg <= frame_next;
        end
    end

    assign frame_valid = frame_valid_reg;
    assign frame       = frame_reg;

endmodule

// ===== rtl/core/mpcd_exec.sv =====
module mpcd_exec
    import mpcd_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [POS_W-1:0] min_position,
    input  logic [POS_W-1:0] max_position,
    input  logic             frame_valid,
    input  frame_t           frame,
    output logic             frame_ready,
    output logic             ex_valid,
    output exec_t            ex,
    input  logic             ex_ready
);

    logic              ex_valid_reg, ex_valid_next;
    exec_t             ex_reg, ex_next;
    logic [DATA_W-1:0] pos_reg, pos_next;

    logic              take;
    logic              emit;
    logic [DATA_W-1:0] value;
    logic [DATA_W-1:0] diff;

    assign frame_ready = !ex_valid_reg || ex_ready;
    assign take        = frame_valid && frame_ready;
    assign value       = frame.negative ? (DATA_W'(0) - frame.value) : frame.value;
    assign diff        = value - pos_reg;

    always_comb begin
        emit              = 1'b1;
        pos_next          = pos_reg;
        ex_next.kind      = KIND_UNKNOWN;
        ex_next.direction = 1'b0;
        ex_next.distance  = '0;
        if (!frame.start_ok) begin
            ex_next.kind = KIND_FRAMING;
        end else begin
            unique case (frame.cmd)
                CMD_AUCAL: begin
                    if (!frame.stop_rev) begin
                        pos_next          = {{(DATA_W-POS_W){1'b0}}, min_position};
                        ex_next.kind      = KIND_HOME;
                        ex_next.direction = 1'b1;
                    end else if (!frame.stop_fwd) begin
                        pos_next     = {{(DATA_W-POS_W){1'b0}}, max_position};
                        ex_next.kind = KIND_HOME;
                    end else begin
                        ex_next.kind = KIND_STOP_ERR;
                    end
                end
                CMD_GETPO: begin
                    ex_next.kind = KIND_REPORT;
                end
                CMD_GO_UP: begin
                    pos_next         = pos_reg + value;
                    ex_next.kind     = KIND_MOVE;
                    ex_next.distance = value;
                end
                CMD_GO_DW: begin
                    pos_next          = pos_reg - value;
                    ex_next.kind      = KIND_MOVE;
                    ex_next.direction = 1'b1;
                    ex_next.distance  = value;
                end
                CMD_GO_TO: begin
                    // already there: nothing to report
                    emit              = (diff != '0);
                    pos_next          = value;
                    ex_next.kind      = KIND_MOVE;
                    ex_next.direction = diff[DATA_W-1];
                    ex_next.distance  = diff[DATA_W-1] ? (DATA_W'(0) - diff) : diff;
                end
                default: begin
                    ex_next.kind = KIND_UNKNOWN;
                end
            endcase
        end
        ex_next.position = pos_next;
        ex_valid_next    = take ? emit : (ex_ready ? 1'b0 : ex_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ex_valid_reg <= 1'b0;
            pos_reg      <= '0;
        end else begin
            ex_valid_reg <= ex_valid_next;
            if (take) begin
                pos_reg <= pos_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            ex_reg <= ex_next;
        end
    end

    assign ex_valid = ex_valid_reg;
    assign ex       = ex_reg;

endmodule

// ===== rtl/core/mpcd_output.sv =====
module mpcd_output
    import mpcd_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic [SPU_W-1:0]         steps_per_unit,
    input  logic                     ex_valid,
    input  exec_t                    ex,
    output logic                     ex_ready,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [2:0]               m_result_kind,
    output logic                     m_direction,
    output logic [DATA_W-1:0]        m_step_count,
    output logic signed [DATA_W-1:0] m_position
);

    logic                    out_valid_reg, out_valid_next;
    kind_t                   kind_reg;
    logic                    dir_reg;
    logic [DATA_W-1:0]       steps_reg;
    logic [DATA_W-1:0]       pos_reg;
    logic                    load;
    logic [DATA_W+SPU_W-1:0] product;

    assign ex_ready = !out_valid_reg || m_ready;
    assign load     = ex_valid && ex_ready;
    // distance is zero for anything but a move, so the product is too
    assign product  = {{SPU_W{1'b0}}, ex.distance} * {{DATA_W{1'b0}}, steps_per_unit};

    assign out_valid_next = load ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg  <= ex.kind;
            dir_reg   <= ex.direction;
            steps_reg <= product[DATA_W-1:0];
            pos_reg   <= ex.position;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_result_kind = kind_reg;
    assign m_direction   = dir_reg;
    assign m_step_count  = steps_reg;
    assign m_position    = pos_reg;

endmodule

// ===== rtl/core/mpcd_checker.sv =====
`include "motor_position_command_decoder_defines.svh"

module mpcd_checker
    import mpcd_pkg::*;
(
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     m_valid,
    input logic                     m_ready,
    input logic [2:0]               m_result_kind,
    input logic                     m_direction,
    input logic [DATA_W-1:0]        m_step_count,
    input logic signed [DATA_W-1:0] m_position
);

    logic [DATA_W-1:0] last_pos_reg, last_pos_next;
    logic              keeps_pos;

    // position seen on the last delivered beat
    assign last_pos_next = (m_valid && m_ready) ? m_position : last_pos_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_pos_reg <= '0;
        end else begin
            last_pos_reg <= last_pos_next;
        end
    end

    assign keeps_pos = (m_result_kind == KIND_REPORT) || (m_result_kind == KIND_STOP_ERR) ||
                       (m_result_kind == KIND_UNKNOWN) || (m_result_kind == KIND_FRAMING);

    `MPCD_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_result_kind) && $stable(m_direction) && $stable(m_step_count) && $stable(m_position), "result beat changed while stalled")
    `MPCD_ASSERT_NOW(a_steps_only_move, m_valid && m_result_kind != KIND_MOVE, m_step_count == '0, "step count on a result that is not a move")
    `MPCD_ASSERT_NOW(a_dir_only_motion, m_valid && m_result_kind != KIND_MOVE && m_result_kind != KIND_HOME, !m_direction, "direction set on a result without motion")
    `MPCD_ASSERT_NOW(a_pos_kept, m_valid && keeps_pos, m_position == last_pos_reg, "position moved on a result that keeps it")

endmodule

bind motor_position_command_decoder mpcd_checker u_checker (.*);
